[sv/tpt_pkg.sv]
// Shared types and codes for the trie prefix table.
`default_nettype none

package tpt_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_PREFIX = 2'd2
	} cmd_e_t;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_POOL_FULL = 1'b1;

	localparam int LETTER_W = 5;

	typedef struct packed {
		cmd_e_t              cmd;
		logic [LETTER_W-1:0] letter;
		logic                last;
		logic                empty;
	} item_t;

	typedef struct packed {
		logic found;
		logic status;
	} result_t;

endpackage

`default_nettype wire

[sv/tpt_engine.sv]
// Trie walker: child table and word marks in synchronous memories, with the walk sequencer.
`default_nettype none

module tpt_engine
	import tpt_pkg::*;
#(
	parameter int NODE_COUNT    = 1024,
	parameter int ALPHABET_SIZE = 26
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    item_valid,
	output logic         item_ready,
	input  wire item_t   item,
	output logic         res_valid,
	input  wire logic    res_ready,
	output result_t      res
);

	localparam int NODE_W      = $clog2(NODE_COUNT);
	localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET_SIZE;
	localparam int ADDR_W      = $clog2(CHILD_DEPTH);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHILD,
		ST_FIN,
		ST_MARK
	} state_t;

	state_t              state_q;
	logic [ADDR_W-1:0]   clr_q;
	cmd_e_t              cmd_q;
	logic                last_q;
	logic [ADDR_W-1:0]   slot_q;
	logic [NODE_W-1:0]   cur_q;
	logic [NODE_W:0]     free_q;
	logic                miss_q;
	logic                ovf_q;

	logic [NODE_W-1:0]   child_mem [CHILD_DEPTH];
	logic                mark_mem  [NODE_COUNT];
	logic [NODE_W-1:0]   ch_rd_q;
	logic                mk_rd_q;

	logic                ch_we;
	logic [ADDR_W-1:0]   ch_wa;
	logic [NODE_W-1:0]   ch_wd;
	logic                mk_we;
	logic [NODE_W-1:0]   mk_wa;
	logic                mk_wd;

	logic [ADDR_W-1:0]   slot_c;
	logic                letter_ok;
	logic                walk_c;
	logic                pool_left;
	logic                alloc;
	logic                node_ok;
	logic                fire;
	logic                clr_mark;

	always_comb begin
		slot_c    = ADDR_W'(32'(cur_q) * 32'(ALPHABET_SIZE) + 32'(item.letter));
		letter_ok = 32'(item.letter) < 32'(ALPHABET_SIZE);
		walk_c    = !item.empty && letter_ok && !miss_q && !ovf_q;
		pool_left = free_q < (NODE_W+1)'(NODE_COUNT);
		alloc     = (ch_rd_q == '0) && (cmd_q == CMD_INSERT) && pool_left;
		node_ok   = !miss_q && !ovf_q;
		clr_mark  = clr_q < ADDR_W'(NODE_COUNT);

		item_ready = (state_q == ST_IDLE);
		res_valid  = ((state_q == ST_FIN) && (cmd_q != CMD_SEARCH)) || (state_q == ST_MARK);
		fire       = res_valid && res_ready;

		res.found  = 1'b0;
		res.status = STATUS_OK;
		unique case (cmd_q)
			CMD_INSERT: begin
				if (ovf_q) begin
					res.status = STATUS_POOL_FULL;
				end else begin
					res.found = node_ok;
				end
			end
			CMD_SEARCH: res.found = node_ok && mk_rd_q;
			default:    res.found = node_ok;
		endcase

		ch_we = (state_q == ST_CLEAR) || ((state_q == ST_CHILD) && alloc);
		ch_wa = (state_q == ST_CLEAR) ? clr_q : slot_q;
		ch_wd = (state_q == ST_CLEAR) ? '0 : free_q[NODE_W-1:0];

		mk_we = ((state_q == ST_CLEAR) && clr_mark)
			|| (fire && (cmd_q == CMD_INSERT) && node_ok);
		mk_wa = (state_q == ST_CLEAR) ? clr_q[NODE_W-1:0] : cur_q;
		mk_wd = (state_q != ST_CLEAR);
	end

	always_ff @(posedge clk) begin
		if (ch_we) begin
			child_mem[ch_wa] <= ch_wd;
		end
		ch_rd_q <= child_mem[slot_c];
	end

	always_ff @(posedge clk) begin
		if (mk_we) begin
			mark_mem[mk_wa] <= mk_wd;
		end
		mk_rd_q <= mark_mem[cur_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			cmd_q   <= CMD_INSERT;
			last_q  <= 1'b0;
			slot_q  <= '0;
			cur_q   <= '0;
			free_q  <= (NODE_W+1)'(1);
			miss_q  <= 1'b0;
			ovf_q   <= 1'b0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == ADDR_W'(CHILD_DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (item_valid) begin
						cmd_q  <= item.cmd;
						last_q <= item.last;
						slot_q <= slot_c;
						if (walk_c) begin
							state_q <= ST_CHILD;
						end else begin
							// a bad letter misses unless the walk has already stopped
							if (!item.empty && !letter_ok && !ovf_q) begin
								miss_q <= 1'b1;
							end
							if (item.last) begin
								state_q <= ST_FIN;
							end
						end
					end
				end
				ST_CHILD: begin
					if (ch_rd_q != '0) begin
						cur_q <= ch_rd_q;
					end else if (cmd_q != CMD_INSERT) begin
						miss_q <= 1'b1;
					end else if (!pool_left) begin
						ovf_q <= 1'b1;
					end else begin
						cur_q  <= free_q[NODE_W-1:0];
						free_q <= free_q + 1'b1;
					end
					state_q <= last_q ? ST_FIN : ST_IDLE;
				end
				ST_FIN: begin
					// search passes through ST_MARK for the word mark read
					if (cmd_q == CMD_SEARCH) begin
						state_q <= ST_MARK;
					end else if (res_ready) begin
						cur_q   <= '0;
						miss_q  <= 1'b0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				ST_MARK: begin
					if (res_ready) begin
						cur_q   <= '0;
						miss_q  <= 1'b0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		free_q <= (NODE_W+1)'(NODE_COUNT))
		else $error("free node counter beyond pool");

	a_cur_alloc: assert property (@(posedge clk) disable iff (!arst_n)
		(NODE_W+1)'(cur_q) < free_q)
		else $error("walk sits on an unallocated node");

	a_stop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(miss_q && ovf_q))
		else $error("miss and pool full both set");

	a_alloc_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHILD && alloc) |=> (free_q == $past(free_q) + 1'b1))
		else $error("allocation did not advance free counter");

	a_clear_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (!res_valid && !item_ready))
		else $error("handshake active during clearing pass");
`endif

endmodule

`default_nettype wire

[sv/trie_prefix_table_top.sv]
// Top level of the trie prefix table: input handshake, walker and output register.
//
//  channel | dir | handshake          | payload
//  in      | in  | in_valid / in_stall  | command, letter, last, empty_req
//  out     | out | out_valid / out_stall| found, status
//
// A letter goes through the child table read, then pointer update or node allocation.
// A last item adds ST_FIN (insert, prefix) or ST_FIN and ST_MARK (search, word mark read);
// an empty item, a letter out of range or an item after the walk has stopped takes
// only the ST_IDLE state when it is not last.
// After reset a clearing pass over all NODE_COUNT * ALPHABET_SIZE child entries
// (26624 at defaults) zeroes both memories; in_stall stays high throughout.
// The output register holds one result, so an item is taken while a result waits.
`default_nettype none

module trie_prefix_table_top
	import tpt_pkg::*;
#(
	parameter int NODE_COUNT    = 1024,
	parameter int ALPHABET_SIZE = 26
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [1:0]          command,
	input  wire logic [LETTER_W-1:0] letter,
	input  wire logic                last,
	input  wire logic                empty_req,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic                     found,
	output logic                     status
);

	item_t   item;
	logic    item_ready;
	logic    res_valid;
	logic    res_ready;
	result_t res;

	logic    out_valid_q;
	logic    found_q;
	logic    status_q;

	assign item.cmd    = cmd_e_t'(command);
	assign item.letter = letter;
	assign item.last   = last;
	assign item.empty  = empty_req;
	assign in_stall    = !item_ready;

	tpt_engine #(
		.NODE_COUNT    (NODE_COUNT),
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (in_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	// refill the output slot as soon as it drains
	assign res_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			found_q  <= res.found;
			status_q <= res.status;
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign status    = status_q;

endmodule

`default_nettype wire
